[design/prime_factor_table_engine_top_assert.svh]
// Assertion macros for the sieve engine.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef PRIME_FACTOR_TABLE_ENGINE_TOP_ASSERT_SVH
`define PRIME_FACTOR_TABLE_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PFTE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("pfte same-cycle check failed");
`define PFTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("pfte next-cycle check failed");
`else
`define PFTE_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define PFTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[design/pfte_pkg.sv]
// Types and constants of the smallest-prime-factor sieve engine.
// No dependencies.
package pfte_pkg;

  localparam int unsigned NUM_W = 16;
  localparam int unsigned EXP_W = 5;
  localparam int unsigned SPF_W = 8;
  localparam int unsigned P_W   = 9;

  localparam logic KIND_BUILD  = 1'b0;
  localparam logic KIND_FACTOR = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUILD = 2'd1,
    ST_RANGE = 2'd2,
    ST_LOW   = 2'd3
  } status_e;

  typedef struct packed {
    logic             written;
    logic [SPF_W-1:0] spf;
    logic [NUM_W-1:0] cof;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_PNEXT  = 8'b0000_0100,
    S_PTEST  = 8'b0000_1000,
    S_MREAD  = 8'b0001_0000,
    S_MWRITE = 8'b0010_0000,
    S_WALK   = 8'b0100_0000,
    S_LAST   = 8'b1000_0000
  } state_e;

endpackage

[design/pfte_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pfte_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/prime_factor_table_engine_top.sv]
// Smallest-prime-factor sieve engine, top level.
// Depends on pfte_pkg, pfte_ram and prime_factor_table_engine_top_assert.svh.
//
// Accepts one word when start_i is high and busy_o is low; results come out on
// res_valid_o strobes, one cycle each, and cannot be held off. A build word
// (kind 0) runs a clearing pass over entries 0..L (L the limit clipped to
// TABLE_DEPTH-1), then tests each candidate p with p*p <= L and, for each p
// found prime, marks its multiples up to L; every table update is a read of
// the table memory followed by a write. A factor word takes one table read per
// prime factor counted with multiplicity (at most 15), then gives the final
// result; an error word gives a single result. Results of one word arrive in
// ascending prime order, last_o on the final one. The limit register is
// written with limit_we_i; the user must write it only while idle, as the
// block itself does not enforce it.
module prime_factor_table_engine_top
  import pfte_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             limit_we_i,
  input  logic [NUM_W-1:0] limit_wdata_i,
  input  logic             start_i,
  output logic             busy_o,
  input  logic             kind_i,
  input  logic [NUM_W-1:0] number_i,
  output logic             res_valid_o,
  output logic [NUM_W-1:0] prime_o,
  output logic [EXP_W-1:0] exponent_o,
  output logic             last_o,
  output logic [1:0]       status_o
);

  localparam int unsigned AW     = $clog2(TABLE_DEPTH);
  localparam int unsigned MaxNum = (TABLE_DEPTH - 1 > 65535) ? 65535 : TABLE_DEPTH - 1;
  localparam logic [NUM_W-1:0] MaxNumW = NUM_W'(MaxNum);

  state_e state_q, state_d;
  logic [NUM_W-1:0] limit_q, blim_q, blim_d, clr_q, clr_d;
  logic             built_q, built_d;
  logic [P_W-1:0]   p_q, p_d;
  logic [NUM_W:0]   m_q, m_d;
  logic [NUM_W-1:0] k_q, k_d, n_q, n_d, cur_q, cur_d;
  logic [EXP_W-1:0] exp_q, exp_d;

  logic             res_valid_q;
  logic [NUM_W-1:0] res_prime_q;
  logic [EXP_W-1:0] res_exp_q;
  logic             res_last_q;
  status_e          res_status_q;

  logic             emit;
  logic [NUM_W-1:0] emit_prime;
  logic [EXP_W-1:0] emit_exp;
  logic             emit_last;
  status_e          emit_status;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  entry_t             rd_ent, wr_ent;

  logic [2*P_W-1:0] p_sq;
  logic [NUM_W-1:0] lim_clip;
  logic [NUM_W-1:0] walk_p, walk_cof;
  logic             walk_same, walk_stop;

  pfte_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_ent    = entry_t'(ram_rdata);
  assign p_sq      = p_q * p_q;
  assign lim_clip  = (limit_q > MaxNumW) ? MaxNumW : limit_q;

  // An unwritten entry is a prime above the sieve bound: its own factor.
  assign walk_p    = rd_ent.written ? {{(NUM_W-SPF_W){1'b0}}, rd_ent.spf} : n_q;
  assign walk_cof  = rd_ent.written ? rd_ent.cof : NUM_W'(1);
  assign walk_same = (walk_p == cur_q);
  assign walk_stop = (walk_cof <= NUM_W'(1)) || (walk_cof >= n_q);

  always_comb begin
    state_d     = state_q;
    blim_d      = blim_q;
    built_d     = built_q;
    clr_d       = clr_q;
    p_d         = p_q;
    m_d         = m_q;
    k_d         = k_q;
    n_d         = n_q;
    cur_d       = cur_q;
    exp_d       = exp_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    wr_ent      = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    emit        = 1'b0;
    emit_prime  = '0;
    emit_exp    = '0;
    emit_last   = 1'b1;
    emit_status = ST_OK;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_BUILD) begin
            blim_d  = lim_clip;
            built_d = 1'b1;
            clr_d   = '0;
            state_d = S_CLEAR;
          end else if (number_i < NUM_W'(2)) begin
            emit        = 1'b1;
            emit_status = ST_LOW;
          end else if (!built_q || number_i > blim_q) begin
            emit        = 1'b1;
            emit_status = ST_RANGE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(number_i);
            n_d       = number_i;
            cur_d     = '0;
            exp_d     = '0;
            state_d   = S_WALK;
          end
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(clr_q);
        if (clr_q == blim_q) begin
          p_d     = P_W'(2);
          state_d = S_PNEXT;
        end else begin
          clr_d = clr_q + NUM_W'(1);
        end
      end
      S_PNEXT: begin
        if (p_sq <= {{(2*P_W-NUM_W){1'b0}}, blim_q}) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(p_q);
          state_d   = S_PTEST;
        end else begin
          emit        = 1'b1;
          emit_status = ST_BUILD;
          state_d     = S_IDLE;
        end
      end
      S_PTEST: begin
        if (rd_ent.written) begin
          p_d     = p_q + P_W'(1);
          state_d = S_PNEXT;
        end else begin
          m_d     = {{(NUM_W+1-P_W){1'b0}}, p_q};
          k_d     = NUM_W'(1);
          state_d = S_MREAD;
        end
      end
      S_MREAD: begin
        if (m_q <= {1'b0, blim_q}) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(m_q);
          state_d   = S_MWRITE;
        end else begin
          p_d     = p_q + P_W'(1);
          state_d = S_PNEXT;
        end
      end
      S_MWRITE: begin
        // Keep the first (smallest) factor that reached this entry.
        if (!rd_ent.written) begin
          ram_we         = 1'b1;
          ram_waddr      = AW'(m_q);
          wr_ent.written = 1'b1;
          wr_ent.spf     = p_q[SPF_W-1:0];
          wr_ent.cof     = k_q;
        end
        m_d     = m_q + {{(NUM_W+1-P_W){1'b0}}, p_q};
        k_d     = k_q + NUM_W'(1);
        state_d = S_MREAD;
      end
      S_WALK: begin
        if (walk_same) begin
          exp_d = exp_q + EXP_W'(1);
        end else begin
          if (cur_q != '0) begin
            emit       = 1'b1;
            emit_prime = cur_q;
            emit_exp   = exp_q;
            emit_last  = 1'b0;
          end
          cur_d = walk_p;
          exp_d = EXP_W'(1);
        end
        if (walk_stop) begin
          state_d = S_LAST;
        end else begin
          n_d       = walk_cof;
          ram_re    = 1'b1;
          ram_raddr = AW'(walk_cof);
        end
      end
      S_LAST: begin
        emit       = 1'b1;
        emit_prime = cur_q;
        emit_exp   = exp_q;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_wdata = ENTRY_W'(wr_ent);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= '1;
      blim_q      <= '0;
      built_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blim_q      <= blim_d;
      built_q     <= built_d;
      res_valid_q <= emit;
      if (limit_we_i) begin
        limit_q <= limit_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    clr_q <= clr_d;
    p_q   <= p_d;
    m_q   <= m_d;
    k_q   <= k_d;
    n_q   <= n_d;
    cur_q <= cur_d;
    exp_q <= exp_d;
    if (emit) begin
      res_prime_q  <= emit_prime;
      res_exp_q    <= emit_exp;
      res_last_q   <= emit_last;
      res_status_q <= emit_status;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign prime_o     = res_prime_q;
  assign exponent_o  = res_exp_q;
  assign last_o      = res_last_q;
  assign status_o    = res_status_q;

`include "prime_factor_table_engine_top_assert.svh"

  `PFTE_ASSERT_SAME(a_err_is_last, clk_i, rst_ni, res_valid_o && (status_o != ST_OK), last_o)
  `PFTE_ASSERT_SAME(a_more_pending, clk_i, rst_ni, res_valid_o && !last_o, busy_o)
  `PFTE_ASSERT_SAME(a_sieve_in_range, clk_i, rst_ni, (state_q == S_MWRITE) && ram_we, m_q <= {1'b0, blim_q})
  `PFTE_ASSERT_SAME(a_walk_spf_valid, clk_i, rst_ni, (state_q == S_WALK) && rd_ent.written, rd_ent.spf >= SPF_W'(2))
  `PFTE_ASSERT_NEXT(a_last_idles, clk_i, rst_ni, state_q == S_LAST, !busy_o && res_valid_o && last_o)

endmodule
